### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Both macros sample on clk_i; the first one is muted while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that only has to hold outside reset.
`define DTD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property that also has to hold while reset is applied.
`define DTD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/dtd_pkg.sv
// Shared types, constants and calendar helper functions of the date-time difference unit.
// Used by dtd_stamp, dtd_diff, the top level and the checker; depends on nothing.
package dtd_pkg;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int SOD_W   = 17;
  localparam int RD_W    = 24;
  localparam int TDAYS_W = 22;
  localparam int TSEC_W  = 39;

  // One date-time on the input bus, and the pair of them.
  localparam int DT_W  = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W;
  localparam int IN_W  = 2 * DT_W;
  localparam int RES_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W + TDAYS_W + TSEC_W;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  localparam int LOAD_STAGES = 3;
  localparam int DIFF_STAGES = 3;
  localparam int STAGES      = LOAD_STAGES + DIFF_STAGES;

  // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y.
  localparam logic [12:0] RECIP_100       = 13'd5243;
  localparam int          RECIP_100_SHIFT = 19;
  localparam int          Q100_W          = 8;

  localparam logic [SOD_W-1:0]   SECS_PER_DAY = 17'd86400;
  localparam logic [RD_W-1:0]    RD_EPOCH_ADJ = 24'd306;
  localparam logic [HOUR_W-1:0]  HOUR_MAX     = 5'd23;
  localparam logic [MIN_W-1:0]   MINUTE_MAX   = 6'd59;
  localparam logic [SEC_W-1:0]   SECOND_MAX   = 6'd59;
  localparam logic [MIN_W-1:0]   MINS_PER_HR  = 6'd60;
  localparam logic [HOUR_W-1:0]  HRS_PER_DAY  = 5'd24;
  localparam logic [MONTH_W+1:0] MONS_PER_YR  = 6'd12;

  localparam logic [MONTH_W-1:0] JAN = 4'd1;
  localparam logic [MONTH_W-1:0] FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MAR = 4'd3;
  localparam logic [MONTH_W-1:0] APR = 4'd4;
  localparam logic [MONTH_W-1:0] MAY = 4'd5;
  localparam logic [MONTH_W-1:0] JUN = 4'd6;
  localparam logic [MONTH_W-1:0] JUL = 4'd7;
  localparam logic [MONTH_W-1:0] AUG = 4'd8;
  localparam logic [MONTH_W-1:0] SEP = 4'd9;
  localparam logic [MONTH_W-1:0] OCT = 4'd10;
  localparam logic [MONTH_W-1:0] NOV = 4'd11;
  localparam logic [MONTH_W-1:0] DEC = 4'd12;

  // The year sits in the lowest bits of a date-time on the bus.
  typedef struct packed {
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } dt_raw_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               leap;
    logic [SOD_W-1:0]   sod;
    logic [RD_W-1:0]    rd;
  } stamp_t;

  typedef struct packed {
    logic [TSEC_W-1:0]  total_seconds;
    logic [TDAYS_W-1:0] total_days;
    logic [SEC_W-1:0]   diff_seconds;
    logic [MIN_W-1:0]   diff_minutes;
    logic [HOUR_W-1:0]  diff_hours;
    logic [DAY_W-1:0]   diff_days;
    logic [MONTH_W-1:0] diff_months;
    logic [YEAR_W-1:0]  diff_years;
  } result_t;

  // Per-stage load enables of the two halves of the pipeline.
  typedef struct packed {
    logic [LOAD_STAGES-1:0] load;
    logic [DIFF_STAGES-1:0] diff;
  } pipe_en_t;

  function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      FEB:                n = leap ? 5'd29 : 5'd28;
      APR, JUN, SEP, NOV: n = 5'd30;
      default:            n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [MONTH_W-1:0] prev_month(logic [MONTH_W-1:0] m);
    return (m == JAN) ? DEC : m - 4'd1;
  endfunction

  // Days from March 1st to the first of the month, counting January and
  // February at the end of the year before.
  function automatic logic [8:0] month_offset(logic [MONTH_W-1:0] m);
    logic [8:0] o;
    case (m)
      JAN:     o = 9'd306;
      FEB:     o = 9'd337;
      MAR:     o = 9'd0;
      APR:     o = 9'd31;
      MAY:     o = 9'd61;
      JUN:     o = 9'd92;
      JUL:     o = 9'd122;
      AUG:     o = 9'd153;
      SEP:     o = 9'd184;
      OCT:     o = 9'd214;
      NOV:     o = 9'd245;
      DEC:     o = 9'd275;
      default: o = 9'd0;
    endcase
    return o;
  endfunction

endpackage

### rtl/core/dtd_stamp.sv
// Three-stage front end: clamps one raw date-time and forms its second of day
// and Rata Die day number. Depends on dtd_pkg.
module dtd_stamp #(
  parameter int unsigned MAX_YEAR = dtd_pkg::MAX_YEAR_DEF
) (
  input  logic              clk_i,
  input  dtd_pkg::pipe_en_t en_i,
  input  dtd_pkg::dt_raw_t  raw_i,
  output dtd_pkg::stamp_t   stamp_o
);

  localparam logic [dtd_pkg::YEAR_W+2:0] YEAR_LIMIT = (dtd_pkg::YEAR_W+3)'(MAX_YEAR);
  localparam int PROD_W = dtd_pkg::YEAR_W + 13;

  // Stage 1: clamp the fields and estimate year / 100.
  logic [dtd_pkg::YEAR_W-1:0]  year_1;
  logic [dtd_pkg::MONTH_W-1:0] month_1;
  logic [dtd_pkg::HOUR_W-1:0]  hour_1;
  logic [dtd_pkg::MIN_W-1:0]   minute_1;
  logic [dtd_pkg::SEC_W-1:0]   second_1;
  logic [PROD_W-1:0]           qprod_1;

  logic [dtd_pkg::YEAR_W-1:0]  year1_q;
  logic [dtd_pkg::MONTH_W-1:0] month1_q;
  logic [dtd_pkg::DAY_W-1:0]   day1_q;
  logic [dtd_pkg::HOUR_W-1:0]  hour1_q;
  logic [dtd_pkg::MIN_W-1:0]   minute1_q;
  logic [dtd_pkg::SEC_W-1:0]   second1_q;
  logic [dtd_pkg::Q100_W-1:0]  cent1_q;

  always_comb begin
    if (raw_i.year == '0) begin
      year_1 = dtd_pkg::YEAR_W'(1);
    end else if ({3'b000, raw_i.year} > YEAR_LIMIT) begin
      year_1 = YEAR_LIMIT[dtd_pkg::YEAR_W-1:0];
    end else begin
      year_1 = raw_i.year;
    end
    if (raw_i.month == '0) begin
      month_1 = dtd_pkg::JAN;
    end else if (raw_i.month > dtd_pkg::DEC) begin
      month_1 = dtd_pkg::DEC;
    end else begin
      month_1 = raw_i.month;
    end
    hour_1   = (raw_i.hour > dtd_pkg::HOUR_MAX) ? dtd_pkg::HOUR_MAX : raw_i.hour;
    minute_1 = (raw_i.minute > dtd_pkg::MINUTE_MAX) ? dtd_pkg::MINUTE_MAX : raw_i.minute;
    second_1 = (raw_i.second > dtd_pkg::SECOND_MAX) ? dtd_pkg::SECOND_MAX : raw_i.second;
    qprod_1  = PROD_W'(year_1) * PROD_W'(dtd_pkg::RECIP_100);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.load[0]) begin
      year1_q   <= year_1;
      month1_q  <= month_1;
      day1_q    <= raw_i.day;
      hour1_q   <= hour_1;
      minute1_q <= minute_1;
      second1_q <= second_1;
      cent1_q   <= qprod_1[dtd_pkg::RECIP_100_SHIFT +: dtd_pkg::Q100_W];
    end
  end

  // Stage 2: leap year, day clamp, second of day and the year part of the day number.
  logic [dtd_pkg::YEAR_W:0]    cent_x100_2;
  logic                        century_2;
  logic                        leap_2;
  logic [dtd_pkg::DAY_W-1:0]   mlen_2;
  logic [dtd_pkg::DAY_W-1:0]   day_2;
  logic                        early_2;
  logic [dtd_pkg::YEAR_W-1:0]  yadj_2;
  logic [dtd_pkg::Q100_W-1:0]  qadj_2;
  logic [dtd_pkg::RD_W-1:0]    base_2;
  logic [dtd_pkg::SOD_W-1:0]   sod_2;

  logic [dtd_pkg::YEAR_W-1:0]  year2_q;
  logic [dtd_pkg::MONTH_W-1:0] month2_q;
  logic [dtd_pkg::DAY_W-1:0]   day2_q;
  logic [dtd_pkg::HOUR_W-1:0]  hour2_q;
  logic [dtd_pkg::MIN_W-1:0]   minute2_q;
  logic [dtd_pkg::SEC_W-1:0]   second2_q;
  logic                        leap2_q;
  logic [dtd_pkg::SOD_W-1:0]   sod2_q;
  logic [dtd_pkg::RD_W-1:0]    base2_q;

  always_comb begin
    cent_x100_2 = (dtd_pkg::YEAR_W+1)'(cent1_q) * (dtd_pkg::YEAR_W+1)'(100);
    century_2   = (cent_x100_2 == {1'b0, year1_q});
    leap_2      = (year1_q[1:0] == 2'b00) && (!century_2 || (cent1_q[1:0] == 2'b00));
    mlen_2      = dtd_pkg::month_len(month1_q, leap_2);
    if (day1_q == '0) begin
      day_2 = dtd_pkg::DAY_W'(1);
    end else if (day1_q > mlen_2) begin
      day_2 = mlen_2;
    end else begin
      day_2 = day1_q;
    end
    // January and February count as months of the year before.
    early_2 = (month1_q < dtd_pkg::MAR);
    yadj_2  = early_2 ? year1_q - dtd_pkg::YEAR_W'(1) : year1_q;
    qadj_2  = (early_2 && century_2) ? cent1_q - dtd_pkg::Q100_W'(1) : cent1_q;
    base_2  = dtd_pkg::RD_W'(yadj_2) * dtd_pkg::RD_W'(365)
            + dtd_pkg::RD_W'(yadj_2 >> 2)
            - dtd_pkg::RD_W'(qadj_2)
            + dtd_pkg::RD_W'(qadj_2 >> 2);
    sod_2   = dtd_pkg::SOD_W'(hour1_q) * dtd_pkg::SOD_W'(3600)
            + dtd_pkg::SOD_W'(minute1_q) * dtd_pkg::SOD_W'(60)
            + dtd_pkg::SOD_W'(second1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.load[1]) begin
      year2_q   <= year1_q;
      month2_q  <= month1_q;
      day2_q    <= day_2;
      hour2_q   <= hour1_q;
      minute2_q <= minute1_q;
      second2_q <= second1_q;
      leap2_q   <= leap_2;
      sod2_q    <= sod_2;
      base2_q   <= base_2;
    end
  end

  // Stage 3: finish the Rata Die day number.
  dtd_pkg::stamp_t stamp_q;

  always_ff @(posedge clk_i) begin
    if (en_i.load[2]) begin
      stamp_q.year   <= year2_q;
      stamp_q.month  <= month2_q;
      stamp_q.day    <= day2_q;
      stamp_q.hour   <= hour2_q;
      stamp_q.minute <= minute2_q;
      stamp_q.second <= second2_q;
      stamp_q.leap   <= leap2_q;
      stamp_q.sod    <= sod2_q;
      stamp_q.rd     <= base2_q + dtd_pkg::RD_W'(dtd_pkg::month_offset(month2_q))
                      + dtd_pkg::RD_W'(day2_q) - dtd_pkg::RD_EPOCH_ADJ;
    end
  end

  assign stamp_o = stamp_q;

endmodule

### rtl/core/dtd_diff.sv
// Three-stage back end: orders two stamps and forms the calendar, day and
// second differences. Depends on dtd_pkg.
module dtd_diff (
  input  logic              clk_i,
  input  dtd_pkg::pipe_en_t en_i,
  input  dtd_pkg::stamp_t   a_i,
  input  dtd_pkg::stamp_t   b_i,
  output dtd_pkg::result_t  res_o
);

  localparam int MUL_W = dtd_pkg::RD_W + dtd_pkg::SOD_W;

  // Stage 4: order the pair and take the day-number difference.
  logic                    a_later_4;
  dtd_pkg::stamp_t         hi_q, lo_q;
  logic [dtd_pkg::RD_W-1:0] tdays_q;

  always_comb begin
    a_later_4 = (a_i.rd > b_i.rd) || ((a_i.rd == b_i.rd) && (a_i.sod > b_i.sod));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.diff[0]) begin
      hi_q    <= a_later_4 ? a_i : b_i;
      lo_q    <= a_later_4 ? b_i : a_i;
      tdays_q <= a_later_4 ? a_i.rd - b_i.rd : b_i.rd - a_i.rd;
    end
  end

  // Stage 5: time-of-day borrows, day borrows and days times seconds per day.
  logic                          tb_5;
  logic [dtd_pkg::SEC_W:0]       sec_raw_5;
  logic [dtd_pkg::MIN_W:0]       min_raw_5;
  logic [dtd_pkg::HOUR_W:0]      hour_raw_5;
  logic [dtd_pkg::SEC_W-1:0]     sec_5;
  logic [dtd_pkg::MIN_W-1:0]     min_5;
  logic [dtd_pkg::HOUR_W-1:0]    hour_5;
  logic [dtd_pkg::DAY_W+1:0]     day0_5, day1_5, day2_5, dayf_5;
  logic [1:0]                    mb_5;
  logic [dtd_pkg::MONTH_W-1:0]   pm_5;
  logic [dtd_pkg::DAY_W-1:0]     ml1_5, ml2_5;
  logic [MUL_W-1:0]              mul_5;

  logic [dtd_pkg::YEAR_W-1:0]    yhi5_q, ylo5_q;
  logic [dtd_pkg::MONTH_W-1:0]   mhi5_q, mlo5_q;
  logic [1:0]                    mb5_q;
  logic [dtd_pkg::DAY_W-1:0]     day5_q;
  logic [dtd_pkg::HOUR_W-1:0]    hour5_q;
  logic [dtd_pkg::MIN_W-1:0]     min5_q;
  logic [dtd_pkg::SEC_W-1:0]     sec5_q;
  logic [dtd_pkg::TDAYS_W-1:0]   tdays5_q;
  logic [dtd_pkg::TSEC_W-1:0]    mul5_q;
  logic [dtd_pkg::SOD_W:0]       sdiff5_q;

  always_comb begin
    tb_5 = (hi_q.sod < lo_q.sod);

    // Borrow chain over seconds, minutes and hours; a time borrow adds a day.
    sec_raw_5  = (dtd_pkg::SEC_W+1)'(hi_q.second) - (dtd_pkg::SEC_W+1)'(lo_q.second);
    sec_5      = sec_raw_5[dtd_pkg::SEC_W] ? sec_raw_5[dtd_pkg::SEC_W-1:0] + dtd_pkg::MINS_PER_HR
                                           : sec_raw_5[dtd_pkg::SEC_W-1:0];
    min_raw_5  = (dtd_pkg::MIN_W+1)'(hi_q.minute) - (dtd_pkg::MIN_W+1)'(lo_q.minute)
               - (dtd_pkg::MIN_W+1)'(sec_raw_5[dtd_pkg::SEC_W]);
    min_5      = min_raw_5[dtd_pkg::MIN_W] ? min_raw_5[dtd_pkg::MIN_W-1:0] + dtd_pkg::MINS_PER_HR
                                           : min_raw_5[dtd_pkg::MIN_W-1:0];
    hour_raw_5 = (dtd_pkg::HOUR_W+1)'(hi_q.hour) - (dtd_pkg::HOUR_W+1)'(lo_q.hour)
               - (dtd_pkg::HOUR_W+1)'(min_raw_5[dtd_pkg::MIN_W]);
    hour_5     = tb_5 ? hour_raw_5[dtd_pkg::HOUR_W-1:0] + dtd_pkg::HRS_PER_DAY
                      : hour_raw_5[dtd_pkg::HOUR_W-1:0];

    // Days borrow the month before the later date's month, and if that is not
    // enough, the month before that one as well.
    pm_5   = dtd_pkg::prev_month(hi_q.month);
    ml1_5  = dtd_pkg::month_len(pm_5, hi_q.leap);
    ml2_5  = dtd_pkg::month_len(dtd_pkg::prev_month(pm_5), hi_q.leap);
    day0_5 = (dtd_pkg::DAY_W+2)'(hi_q.day) - (dtd_pkg::DAY_W+2)'(lo_q.day)
           - (dtd_pkg::DAY_W+2)'(tb_5);
    day1_5 = day0_5 + (dtd_pkg::DAY_W+2)'(ml1_5);
    day2_5 = day1_5 + (dtd_pkg::DAY_W+2)'(ml2_5);
    if (!day0_5[dtd_pkg::DAY_W+1]) begin
      dayf_5 = day0_5;
      mb_5   = 2'd0;
    end else if (!day1_5[dtd_pkg::DAY_W+1]) begin
      dayf_5 = day1_5;
      mb_5   = 2'd1;
    end else begin
      dayf_5 = day2_5;
      mb_5   = 2'd2;
    end

    mul_5 = MUL_W'(tdays_q) * MUL_W'(dtd_pkg::SECS_PER_DAY);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.diff[1]) begin
      yhi5_q   <= hi_q.year;
      ylo5_q   <= lo_q.year;
      mhi5_q   <= hi_q.month;
      mlo5_q   <= lo_q.month;
      mb5_q    <= mb_5;
      day5_q   <= dayf_5[dtd_pkg::DAY_W-1:0];
      hour5_q  <= hour_5;
      min5_q   <= min_5;
      sec5_q   <= sec_5;
      tdays5_q <= tdays_q[dtd_pkg::TDAYS_W-1:0];
      mul5_q   <= mul_5[dtd_pkg::TSEC_W-1:0];
      sdiff5_q <= (dtd_pkg::SOD_W+1)'(hi_q.sod) - (dtd_pkg::SOD_W+1)'(lo_q.sod);
    end
  end

  // Stage 6: month and year borrows, total seconds; this register drives the output.
  logic [dtd_pkg::MONTH_W+1:0] mon_raw_6, mon_a_6, mon_b_6;
  logic [1:0]                  yb_6;
  logic [dtd_pkg::YEAR_W+1:0]  yr_raw_6;
  logic [dtd_pkg::YEAR_W-1:0]  yr_6;
  logic [dtd_pkg::TSEC_W-1:0]  tsec_6;
  dtd_pkg::result_t            res_q;

  always_comb begin
    mon_raw_6 = (dtd_pkg::MONTH_W+2)'(mhi5_q) - (dtd_pkg::MONTH_W+2)'(mlo5_q)
              - (dtd_pkg::MONTH_W+2)'(mb5_q);
    mon_a_6   = mon_raw_6[dtd_pkg::MONTH_W+1] ? mon_raw_6 + dtd_pkg::MONS_PER_YR : mon_raw_6;
    mon_b_6   = mon_a_6[dtd_pkg::MONTH_W+1] ? mon_a_6 + dtd_pkg::MONS_PER_YR : mon_a_6;
    yb_6      = 2'(mon_raw_6[dtd_pkg::MONTH_W+1]) + 2'(mon_a_6[dtd_pkg::MONTH_W+1]);
    yr_raw_6  = (dtd_pkg::YEAR_W+2)'(yhi5_q) - (dtd_pkg::YEAR_W+2)'(ylo5_q)
              - (dtd_pkg::YEAR_W+2)'(yb_6);
    yr_6      = yr_raw_6[dtd_pkg::YEAR_W+1] ? '0 : yr_raw_6[dtd_pkg::YEAR_W-1:0];
    tsec_6    = mul5_q + {{(dtd_pkg::TSEC_W-dtd_pkg::SOD_W-1){sdiff5_q[dtd_pkg::SOD_W]}},
                          sdiff5_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.diff[2]) begin
      res_q.diff_years    <= yr_6;
      res_q.diff_months   <= mon_b_6[dtd_pkg::MONTH_W-1:0];
      res_q.diff_days     <= day5_q;
      res_q.diff_hours    <= hour5_q;
      res_q.diff_minutes  <= min5_q;
      res_q.diff_seconds  <= sec5_q;
      res_q.total_days    <= tdays5_q;
      res_q.total_seconds <= tsec_6;
    end
  end

  assign res_o = res_q;

endmodule

### rtl/core/date_time_difference_unit.sv
// Top level of the date-time difference unit: stream ports, pipeline valid chain,
// two dtd_stamp front ends and the dtd_diff back end. Depends on dtd_pkg.
//
// Usage:
//   Each beat on the slave channel carries two Gregorian date-times A and B.
//   Out-of-range fields are clamped (years to 1..MAX_YEAR, months to 1..12,
//   days to the month length, hours to 23, minutes and seconds to 59).
//   Each beat on the master channel carries one result: the calendar difference
//   (years, months, days, hours, minutes, seconds) from the earlier to the later
//   date-time, the difference of their Rata Die day numbers and the total
//   elapsed seconds. Equal inputs give all zeros.
//   Each result beat passes through six register stages: clamp, leap year and
//   day clamp, day number, ordering, time and day borrows, month and year
//   borrows. Throughput is one beat per cycle while m_axis_tready is high;
//   each stage has its own valid bit, so a bubble anywhere is squeezed out and
//   s_axis_tready stays high while any stage ahead of the output is free, even
//   with a result waiting.
//   When m_axis_tready is low the output beat holds and the stages behind it
//   fill up; nothing is dropped or repeated.
//   Reset (rst_ni low, asynchronous) empties the pipeline; there is no other state.
module date_time_difference_unit #(
  parameter int unsigned MAX_YEAR = dtd_pkg::MAX_YEAR_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // Low to high: year_a, month_a, day_a, hour_a, minute_a, second_a,
  //              year_b, month_b, day_b, hour_b, minute_b, second_b.
  input  logic [dtd_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // Low to high: diff_years, diff_months, diff_days, diff_hours, diff_minutes,
  //              diff_seconds, total_days, total_seconds, zero padding.
  output logic [dtd_pkg::OUT_W-1:0]  m_axis_tdata
);

  logic [dtd_pkg::STAGES-1:0] vld_q, vld_d, rdy;
  dtd_pkg::pipe_en_t          en;
  dtd_pkg::dt_raw_t           raw_a, raw_b;
  dtd_pkg::stamp_t            stamp_a, stamp_b;
  dtd_pkg::result_t           res;

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    rdy[dtd_pkg::STAGES-1] = !vld_q[dtd_pkg::STAGES-1] || m_axis_tready;
    for (int k = dtd_pkg::STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < dtd_pkg::STAGES; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en.load = rdy[dtd_pkg::LOAD_STAGES-1:0];
  assign en.diff = rdy[dtd_pkg::STAGES-1:dtd_pkg::LOAD_STAGES];

  assign raw_a = s_axis_tdata[dtd_pkg::DT_W-1:0];
  assign raw_b = s_axis_tdata[dtd_pkg::IN_W-1:dtd_pkg::DT_W];

  dtd_stamp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_stamp_a (
    .clk_i   (clk_i),
    .en_i    (en),
    .raw_i   (raw_a),
    .stamp_o (stamp_a)
  );

  dtd_stamp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_stamp_b (
    .clk_i   (clk_i),
    .en_i    (en),
    .raw_i   (raw_b),
    .stamp_o (stamp_b)
  );

  dtd_diff u_diff (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (stamp_a),
    .b_i   (stamp_b),
    .res_o (res)
  );

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[dtd_pkg::STAGES-1];
  assign m_axis_tdata  = {{(dtd_pkg::OUT_W-dtd_pkg::RES_W){1'b0}}, res};

endmodule

### rtl/core/dtd_checker.sv
// Port-level checks of the date-time difference unit, bound to the top level.
// Depends on dtd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dtd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [dtd_pkg::OUT_W-1:0] m_axis_tdata
);

  logic out_stall;
  logic fields_ok;

  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // Calendar fields stay in their ranges and the byte padding stays zero.
  assign fields_ok = (m_axis_tdata[17:14] < 4'd12) && (m_axis_tdata[22:18] < 5'd31)
                   && (m_axis_tdata[27:23] < 5'd24) && (m_axis_tdata[33:28] < 6'd60)
                   && (m_axis_tdata[39:34] < 6'd60) && (m_axis_tdata[103:101] == 3'd0);

  // A held result beat must not change under the consumer.
  `DTD_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "held beat changed")

  // With the output stage empty, every stage behind it can take a beat.
  `DTD_ASSERT(a_ready_when_drained, !m_axis_tvalid |-> s_axis_tready, "input stalled when drained")

  // Reset empties the pipeline.
  `DTD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !m_axis_tvalid, "result shown during reset")

  `DTD_ASSERT(a_field_ranges, m_axis_tvalid |-> fields_ok, "result field out of range")

endmodule

bind date_time_difference_unit dtd_checker u_dtd_checker (.*);

### bench/tb_date_time_difference_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for date_time_difference_unit: directed calendar corner cases,
// then random date-time pairs with random gaps and output stalls.
// Depends on dtd_pkg and the RTL of the unit only.
module tb_date_time_difference_unit;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned RANDOM_PAIRS = 1200;
  localparam longint DAY_SECS = 86400;

  // Bit offsets of the fields inside one date-time on the input bus.
  localparam int MONTH_LSB  = dtd_pkg::YEAR_W;
  localparam int DAY_LSB    = MONTH_LSB + dtd_pkg::MONTH_W;
  localparam int HOUR_LSB   = DAY_LSB + dtd_pkg::DAY_W;
  localparam int MINUTE_LSB = HOUR_LSB + dtd_pkg::HOUR_W;
  localparam int SECOND_LSB = MINUTE_LSB + dtd_pkg::MIN_W;

  typedef struct {
    longint year;
    longint month;
    longint day;
    longint sod;
    longint rd;
  } civil_stamp_t;

  class diff_scoreboard;
    dtd_pkg::result_t expected_diffs[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function automatic longint days_in_month(longint y, longint m);
      if (m == dtd_pkg::FEB) begin
        return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
      end
      if (m == dtd_pkg::APR || m == dtd_pkg::JUN || m == dtd_pkg::SEP || m == dtd_pkg::NOV)
      begin
        return 30;
      end
      return 31;
    endfunction

    function automatic longint month_before(longint m);
      return (m == dtd_pkg::JAN) ? dtd_pkg::DEC : m - 1;
    endfunction

    // Clamps every field into its legal range, then forms the second of day and
    // the day number counted from 0001-01-01 as day 1.
    function automatic civil_stamp_t load_stamp(logic [dtd_pkg::DT_W-1:0] raw);
      civil_stamp_t st;
      longint h, mi, s, y, m;
      st.year  = raw[MONTH_LSB-1:0];
      st.month = raw[DAY_LSB-1:MONTH_LSB];
      st.day   = raw[HOUR_LSB-1:DAY_LSB];
      h        = raw[MINUTE_LSB-1:HOUR_LSB];
      mi       = raw[SECOND_LSB-1:MINUTE_LSB];
      s        = raw[dtd_pkg::DT_W-1:SECOND_LSB];
      if (st.year < 1) st.year = 1;
      if (st.year > dtd_pkg::MAX_YEAR_DEF) st.year = dtd_pkg::MAX_YEAR_DEF;
      if (st.month < 1) st.month = 1;
      if (st.month > 12) st.month = 12;
      if (st.day < 1) st.day = 1;
      if (st.day > days_in_month(st.year, st.month)) st.day = days_in_month(st.year, st.month);
      if (h > 23) h = 23;
      if (mi > 59) mi = 59;
      if (s > 59) s = 59;
      st.sod = h * 3600 + mi * 60 + s;
      y = st.year;
      m = st.month;
      // January and February count as months 13 and 14 of the year before.
      if (m < 3) begin
        y = y - 1;
        m = m + 12;
      end
      st.rd = 365 * y + y / 4 - y / 100 + y / 400 + (153 * m - 457) / 5 + st.day - 306;
      return st;
    endfunction

    function automatic dtd_pkg::result_t predict_difference(logic [dtd_pkg::IN_W-1:0] pair);
      civil_stamp_t a, b, lo, hi;
      longint tb, tdiff, day, mon, yr, mb, yb, pm, tdays, tsecs;
      dtd_pkg::result_t r;
      a = load_stamp(pair[dtd_pkg::DT_W-1:0]);
      b = load_stamp(pair[dtd_pkg::IN_W-1:dtd_pkg::DT_W]);
      if (a.rd > b.rd || (a.rd == b.rd && a.sod > b.sod)) begin
        lo = b;
        hi = a;
      end else begin
        lo = a;
        hi = b;
      end
      tb = (hi.sod < lo.sod) ? 1 : 0;
      tdiff = hi.sod + tb * DAY_SECS - lo.sod;
      // The day part borrows from the months before the later date's month,
      // at most twice.
      day = hi.day - tb - lo.day;
      pm = month_before(hi.month);
      mb = 0;
      if (day < 0) begin
        day = day + days_in_month(hi.year, pm);
        mb = 1;
        if (day < 0) begin
          day = day + days_in_month(hi.year, month_before(pm));
          mb = 2;
        end
      end
      mon = hi.month - lo.month - mb;
      yb = 0;
      if (mon < 0) begin
        mon = mon + 12;
        yb++;
      end
      if (mon < 0) begin
        mon = mon + 12;
        yb++;
      end
      yr = hi.year - lo.year - yb;
      if (yr < 0) yr = 0;
      tdays = hi.rd - lo.rd;
      tsecs = tdays * DAY_SECS + hi.sod - lo.sod;
      r.diff_years    = yr[dtd_pkg::YEAR_W-1:0];
      r.diff_months   = mon[dtd_pkg::MONTH_W-1:0];
      r.diff_days     = day[dtd_pkg::DAY_W-1:0];
      r.diff_hours    = dtd_pkg::HOUR_W'(tdiff / 3600);
      r.diff_minutes  = dtd_pkg::MIN_W'((tdiff % 3600) / 60);
      r.diff_seconds  = dtd_pkg::SEC_W'(tdiff % 60);
      r.total_days    = tdays[dtd_pkg::TDAYS_W-1:0];
      r.total_seconds = tsecs[dtd_pkg::TSEC_W-1:0];
      return r;
    endfunction

    function void note_pair(logic [dtd_pkg::IN_W-1:0] pair);
      expected_diffs.push_back(predict_difference(pair));
    endfunction

    function int unsigned pending();
      return expected_diffs.size();
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_diff(logic [dtd_pkg::OUT_W-1:0] beat);
      dtd_pkg::result_t got, want;
      got = dtd_pkg::result_t'(beat[dtd_pkg::RES_W-1:0]);
      if (expected_diffs.size() == 0) begin
        $error("result beat arrived with no date pair outstanding");
        mismatches++;
        return;
      end
      want = expected_diffs.pop_front();
      compare_field("diff_years", want.diff_years, got.diff_years);
      compare_field("diff_months", want.diff_months, got.diff_months);
      compare_field("diff_days", want.diff_days, got.diff_days);
      compare_field("diff_hours", want.diff_hours, got.diff_hours);
      compare_field("diff_minutes", want.diff_minutes, got.diff_minutes);
      compare_field("diff_seconds", want.diff_seconds, got.diff_seconds);
      compare_field("total_days", want.total_days, got.total_days);
      compare_field("total_seconds", want.total_seconds, got.total_seconds);
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [dtd_pkg::IN_W-1:0]   s_axis_tdata = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [dtd_pkg::OUT_W-1:0]  m_axis_tdata;

  diff_scoreboard board = new();
  bit no_idle = 1'b0;
  int unsigned cycle_count = 0;

  date_time_difference_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [dtd_pkg::DT_W-1:0] dt(int y, int m, int d, int h, int mi, int s);
    return {dtd_pkg::SEC_W'(s), dtd_pkg::MIN_W'(mi), dtd_pkg::HOUR_W'(h),
            dtd_pkg::DAY_W'(d), dtd_pkg::MONTH_W'(m), dtd_pkg::YEAR_W'(y)};
  endfunction

  function automatic logic [dtd_pkg::IN_W-1:0] pair_of(logic [dtd_pkg::DT_W-1:0] a,
                                                       logic [dtd_pkg::DT_W-1:0] b);
    return {b, a};
  endfunction

  function automatic logic [dtd_pkg::DT_W-1:0] random_stamp(int y);
    return dt(y, $urandom_range(1, 12), $urandom_range(1, 31),
              $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  // Mostly legal date-times, many of them close together so that the borrows
  // fire often, plus some raw bit patterns that exercise the clamping.
  function automatic logic [dtd_pkg::IN_W-1:0] random_pair();
    logic [95:0] noise;
    logic [dtd_pkg::DT_W-1:0] a, b, t;
    int unsigned sel;
    int y;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      noise = {$urandom, $urandom, $urandom};
      return noise[dtd_pkg::IN_W-1:0];
    end
    if (sel < 45) begin
      return pair_of(random_stamp($urandom_range(1, 9999)), random_stamp($urandom_range(1, 9999)));
    end
    y = $urandom_range(1, 9998);
    a = random_stamp(y);
    if (sel < 60) begin
      // Same date, only the time of day differs.
      b = a;
      t = random_stamp(y);
      b[dtd_pkg::DT_W-1:HOUR_LSB] = t[dtd_pkg::DT_W-1:HOUR_LSB];
    end else begin
      b = random_stamp(y + $urandom_range(0, 1));
    end
    return ($urandom_range(0, 1) != 0) ? pair_of(a, b) : pair_of(b, a);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_pair(logic [dtd_pkg::IN_W-1:0] pair);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= pair;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_pair(pair);
  endtask

  task automatic wait_for_results();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: checks each beat and stalls at random.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_diff(m_axis_tdata);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 25) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    // The falling edge lands after every process waits on it.
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Raw all-zero and all-one words clamp to equal date-times.
    send_pair('0);
    send_pair('1);
    send_pair(pair_of(dt(9999, 12, 31, 23, 59, 59), dt(1, 1, 1, 0, 0, 0)));
    send_pair(pair_of(dt(1, 1, 1, 0, 0, 0), dt(9999, 12, 31, 23, 59, 59)));
    send_pair(pair_of(dt(2024, 7, 4, 12, 30, 15), dt(2024, 7, 4, 12, 30, 15)));
    send_pair(pair_of(dt(2024, 7, 4, 17, 45, 30), dt(2024, 7, 4, 8, 0, 0)));
    // January 31st to March 1st needs a second month borrow.
    send_pair(pair_of(dt(2023, 3, 1, 0, 0, 0), dt(2023, 1, 31, 0, 0, 0)));
    send_pair(pair_of(dt(2024, 3, 1, 0, 0, 0), dt(2024, 1, 31, 0, 0, 0)));
    send_pair(pair_of(dt(2023, 1, 30, 0, 0, 0), dt(2023, 3, 1, 0, 0, 0)));
    // Same day of month, but the time of day borrows a day.
    send_pair(pair_of(dt(2020, 5, 15, 10, 0, 0), dt(2020, 6, 15, 9, 0, 0)));
    send_pair(pair_of(dt(2000, 2, 29, 23, 0, 0), dt(2000, 3, 1, 1, 0, 0)));
    send_pair(pair_of(dt(1900, 3, 1, 0, 0, 0), dt(1900, 2, 28, 0, 0, 0)));
    send_pair(pair_of(dt(2023, 2, 30, 0, 0, 0), dt(2023, 3, 1, 0, 0, 0)));
    send_pair(pair_of(dt(2010, 0, 5, 1, 2, 3), dt(2010, 13, 5, 3, 2, 1)));
    send_pair(pair_of(dt(0, 6, 1, 0, 0, 0), dt(10000, 6, 1, 0, 0, 0)));
    send_pair(pair_of(dt(2015, 4, 31, 24, 60, 63), dt(2015, 4, 0, 31, 63, 60)));
    send_pair(pair_of(dt(2021, 12, 31, 23, 59, 59), dt(2022, 1, 1, 0, 0, 0)));
    send_pair(pair_of(dt(2022, 1, 5, 0, 0, 0), dt(2021, 12, 20, 0, 0, 0)));
    send_pair(pair_of(dt(2020, 12, 31, 12, 0, 0), dt(2022, 3, 1, 6, 0, 0)));
    send_pair(pair_of(dt(2100, 2, 29, 0, 0, 0), dt(2096, 2, 29, 0, 0, 0)));

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      no_idle = (i >= 300 && i < 450);
      if (i == 700) begin
        // Let the pipeline empty completely before going on.
        s_axis_tvalid <= 1'b0;
        wait_for_results();
      end
      send_pair(random_pair());
    end
    s_axis_tvalid <= 1'b0;

    wait_for_results();
    repeat (12) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
